/* rtl/vbtc_pkg.sv */
// Package for the virtual-to-bus translation cache.
// Holds action codes, the cache write-control struct and default sizes.
// No dependencies.
package vbtc_pkg;

  localparam int ADDR_W                   = 32;
  localparam int CNT_W                    = 32;
  localparam int DEFAULT_ENTRIES          = 8;
  localparam int DEFAULT_PAGE_OFFSET_BITS = 12;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_REFILL = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef struct packed {
    logic refill;
    logic flush;
  } cam_ctrl_t;

endpackage

/* rtl/vbtc_cam.sv */
// Tag store of the translation cache: valid bits, tags and bus pages,
// parallel tag compare with lowest-index priority. Depends on vbtc_pkg.
module vbtc_cam
  import vbtc_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES,
  parameter int TAG_W   = ADDR_W - DEFAULT_PAGE_OFFSET_BITS,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  cam_ctrl_t        ctrl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [TAG_W-1:0] wr_tag,
  input  logic [TAG_W-1:0] wr_page,
  input  logic [TAG_W-1:0] lk_tag,
  output logic             lk_hit,
  output logic [TAG_W-1:0] lk_page
);

  logic [ENTRIES-1:0] valid;
  logic [TAG_W-1:0]   tags  [ENTRIES];
  logic [TAG_W-1:0]   pages [ENTRIES];
  logic [ENTRIES-1:0] match;

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      valid <= '0;
    end else if (ctrl.refill) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.refill) begin
      tags[wr_idx]  <= wr_tag;
      pages[wr_idx] <= wr_page;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (tags[i] == lk_tag);
    end
  end

  // first match wins
  always_comb begin
    logic seen;
    seen    = 1'b0;
    lk_page = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i] && !seen) begin
        lk_page = pages[i];
      end
      seen = seen | match[i];
    end
    lk_hit = seen;
  end

endmodule

/* rtl/virt_to_bus_translation_cache.sv */
// Top level of the virtual-to-bus translation cache: input register,
// action decode, counters and result register. Depends on vbtc_pkg, vbtc_cam.
//
// Usage:
//   Request words enter on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser carries
//   the action (lookup, refill, flush, no-op); s_tdata carries the virtual
//   address and the bus address from the external page walk.
//   One result word leaves on m_tvalid/m_tready/m_tdata/m_tuser per request:
//   m_tuser is the hit flag, m_tdata holds bus address and both running
//   totals.
//   Each accepted word sits in the input register, where the tag compare and
//   state update happen, then lands in the result register, which drives
//   m_tvalid. One request per cycle is sustained while the receiver does not
//   stall; the parallel tag compare across all entries is combinational.
//   When the receiver stalls, the result register holds and the input
//   register takes one more word, then s_tready drops until the result moves.
//   Reset (synchronous) invalidates all entries, clears the insert pointer,
//   both counters and both pipeline valid flags. Tags and pages are not reset.
module virt_to_bus_translation_cache
  import vbtc_pkg::*;
#(
  parameter int ENTRIES          = DEFAULT_ENTRIES,
  parameter int PAGE_OFFSET_BITS = DEFAULT_PAGE_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // virt_addr[31:0], walk_bus_addr[63:32]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // xlate_addr[31:0], hit_total[63:32], miss_total[95:64]
  output logic        m_tuser    // hit[0]
);

  localparam int TAG_W = ADDR_W - PAGE_OFFSET_BITS;
  localparam int IDX_W = $clog2(ENTRIES);

  logic              in_valid;
  action_t           in_action;
  logic [ADDR_W-1:0] in_vaddr;
  logic [ADDR_W-1:0] in_walk;

  logic              out_hit;
  logic [ADDR_W-1:0] out_bus;
  logic [CNT_W-1:0]  hit_counter;
  logic [CNT_W-1:0]  miss_counter;
  logic [IDX_W-1:0]  insert_ptr;

  logic              advance;
  cam_ctrl_t         ctrl;
  logic              lk_hit;
  logic [TAG_W-1:0]  lk_page;
  logic              hit_next;
  logic [ADDR_W-1:0] bus_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= action_t'(s_tuser);
      in_vaddr  <= s_tdata[31:0];
      in_walk   <= s_tdata[63:32];
    end
  end

  vbtc_cam #(
    .ENTRIES (ENTRIES),
    .TAG_W   (TAG_W),
    .IDX_W   (IDX_W)
  ) u_cam (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .wr_idx  (insert_ptr),
    .wr_tag  (in_vaddr[ADDR_W-1:PAGE_OFFSET_BITS]),
    .wr_page (in_walk[ADDR_W-1:PAGE_OFFSET_BITS]),
    .lk_tag  (in_vaddr[ADDR_W-1:PAGE_OFFSET_BITS]),
    .lk_hit  (lk_hit),
    .lk_page (lk_page)
  );

  always_comb begin
    ctrl     = '0;
    hit_next = 1'b0;
    bus_next = '0;
    case (in_action)
      ACT_LOOKUP: begin
        if (lk_hit) begin
          hit_next = 1'b1;
          bus_next = {lk_page, in_vaddr[PAGE_OFFSET_BITS-1:0]};
        end
      end
      ACT_REFILL: begin
        if (in_walk != '0) begin
          ctrl.refill = advance;
          bus_next    = in_walk;
        end
      end
      ACT_FLUSH: begin
        ctrl.flush = advance;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_ptr   <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else begin
      if (ctrl.flush) begin
        insert_ptr <= '0;
      end else if (ctrl.refill) begin
        insert_ptr <= (insert_ptr == IDX_W'(ENTRIES - 1)) ? '0 : insert_ptr + 1'b1;
        miss_counter <= miss_counter + 1'b1;
      end
      if (advance && hit_next) begin
        hit_counter <= hit_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit <= hit_next;
      out_bus <= bus_next;
    end
  end

  // counters only change on advance, so they track the held result word
  assign m_tdata = {miss_counter, hit_counter, out_bus};
  assign m_tuser = out_hit;

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    advance && hit_next |=> hit_counter == $past(hit_counter) + 1'b1)
    else $error("hit counter did not advance on a lookup hit");

  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(hit_counter) && $stable(miss_counter))
    else $error("counters changed without an advancing word");

  a_hit_from_lookup: assert property (@(posedge clk) disable iff (rst)
    advance && in_action != ACT_LOOKUP |=> !out_hit)
    else $error("hit flag set for a non-lookup word");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    insert_ptr <= IDX_W'(ENTRIES - 1))
    else $error("insert pointer out of range");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for virt_to_bus_translation_cache: directed and random lookup, refill,
// flush and no-op words with random stalls on both streams, checked against a
// scoreboard that tracks the translation entries. Depends on vbtc_pkg and the RTL.
module tb_top
  import vbtc_pkg::*;
();

  localparam int PAGE_BITS    = DEFAULT_PAGE_OFFSET_BITS;
  localparam int VPN_W        = ADDR_W - PAGE_BITS;
  localparam int RANDOM_ITEMS = 1900;
  localparam int POOL_SIZE    = 12;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] xlate_addr;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
  } xlate_result_t;

  class xlate_scoreboard;
    logic              entry_valid [DEFAULT_ENTRIES];
    logic [VPN_W-1:0]  entry_vpage [DEFAULT_ENTRIES];
    logic [VPN_W-1:0]  entry_bpage [DEFAULT_ENTRIES];
    int unsigned       next_slot;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  refills;
    xlate_result_t     pending [$];
    int                errors;

    function new();
      foreach (entry_valid[i]) entry_valid[i] = 1'b0;
      next_slot = 0;
      hits      = '0;
      refills   = '0;
      errors    = 0;
    endfunction

    function void note_request(action_t act, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] wa);
      xlate_result_t    r;
      logic [VPN_W-1:0] vpn;
      r   = '0;
      vpn = va[ADDR_W-1:PAGE_BITS];
      case (act)
        ACT_LOOKUP: begin
          // lowest-indexed match wins when duplicates exist
          for (int i = 0; i < DEFAULT_ENTRIES; i++) begin
            if (!r.hit && entry_valid[i] && entry_vpage[i] == vpn) begin
              r.hit        = 1'b1;
              r.xlate_addr = {entry_bpage[i], va[PAGE_BITS-1:0]};
            end
          end
          if (r.hit) hits = hits + 1'b1;
        end
        ACT_REFILL: begin
          if (wa != '0) begin
            entry_valid[next_slot] = 1'b1;
            entry_vpage[next_slot] = vpn;
            entry_bpage[next_slot] = wa[ADDR_W-1:PAGE_BITS];
            next_slot    = (next_slot + 1 >= DEFAULT_ENTRIES) ? 0 : next_slot + 1;
            refills      = refills + 1'b1;
            r.xlate_addr = wa;
          end
        end
        ACT_FLUSH: begin
          foreach (entry_valid[i]) entry_valid[i] = 1'b0;
          next_slot = 0;
        end
        default: ;
      endcase
      r.hit_total  = hits;
      r.miss_total = refills;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic hit, logic [95:0] data);
      xlate_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, got hit=%b data=%h",
                 $time, hit, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("hit", {31'b0, want.hit}, {31'b0, hit});
      compare_field("xlate_addr", want.xlate_addr, data[31:0]);
      compare_field("hit_total", want.hit_total, data[63:32]);
      compare_field("miss_total", want.miss_total, data[95:64]);
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // virt_addr[31:0], walk_bus_addr[63:32]
  logic [1:0]  s_tuser  = ACT_NOP;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;   // xlate_addr[31:0], hit_total[63:32], miss_total[95:64]
  logic        m_tuser;   // hit[0]

  xlate_scoreboard sb = new();

  int          cycle_count     = 0;
  int          hold_off_cycles = 0;
  int          send_run_left   = 0;
  bit          send_eager      = 1'b0;
  logic [19:0] page_pool [POOL_SIZE];

  virt_to_bus_translation_cache dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, eager stretches, one long hold-off on request
  initial begin : result_sink
    int stall;
    int run_left;
    bit eager;
    run_left = 0;
    eager    = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (run_left == 0) begin
        eager    = ($urandom_range(0, 2) == 0);
        run_left = $urandom_range(16, 64);
      end
      run_left--;
      stall = eager ? 0 : $urandom_range(0, 7);
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tuser, m_tdata);
    end
  end

  task automatic send_word(input action_t act, input logic [31:0] va, input logic [31:0] wa);
    int gap;
    if (send_run_left == 0) begin
      send_eager    = ($urandom_range(0, 2) == 0);
      send_run_left = $urandom_range(16, 64);
    end
    send_run_left--;
    gap = send_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {wa, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(act, va, wa);
  endtask

  initial begin : stimulus
    int          pick;
    logic [31:0] va;
    logic [31:0] wa;
    action_t     act;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cache, failed walk, address extremes, duplicates, flush
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_REFILL, 32'h1234_5678, 32'h0000_0000);
    send_word(ACT_REFILL, 32'h0000_0ABC, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'h0000_0FFF, 32'hFFFF_FFFF);
    send_word(ACT_REFILL, 32'hFFFF_F123, 32'h0000_0001);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_NOP,    32'h0000_0000, 32'h0000_0000);
    send_word(ACT_REFILL, 32'h0000_0555, 32'hABCD_E000);
    send_word(ACT_LOOKUP, 32'h0000_0123, 32'h0000_0000);
    send_word(ACT_FLUSH,  32'h0000_0000, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'hFFFF_F000, 32'h0000_0000);
    // ten refills wrap the insert pointer past the last entry
    for (int k = 0; k < 10; k++)
      send_word(ACT_REFILL, {20'h00040 + 20'(k), 12'h3C5}, {20'hA5000 + 20'(k), 12'h5A3});
    send_word(ACT_LOOKUP, 32'h0004_0000, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'h0004_9FFF, 32'h0000_0000);

    foreach (page_pool[i]) page_pool[i] = 20'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_off_cycles = 400;
      if ($urandom_range(0, 99) == 0)
        page_pool[$urandom_range(0, POOL_SIZE - 1)] = 20'($urandom);
      if ($urandom_range(0, 9) == 0)
        va = $urandom;
      else
        va = {page_pool[$urandom_range(0, POOL_SIZE - 1)], 12'($urandom)};
      wa   = ($urandom_range(0, 29) == 0) ? 32'h0 : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        act = ACT_LOOKUP;
      else if (pick < 90)
        act = ACT_REFILL;
      else if (pick < 92)
        act = ACT_FLUSH;
      else
        act = ACT_NOP;
      send_word(act, va, wa);
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
